@@ src/oqrf_pkg.sv @@
// Shared types, constants and helper functions for the record queue framer.
// Has no dependencies. Every other file in src except oqrf_ram imports it.

package oqrf_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = 8;
   localparam int RECORD_W    = 64;
   localparam int FRAME_LEN   = 10;
   localparam int BYTE_IDX_W  = $clog2(FRAME_LEN);

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = BYTE_IDX_W'(FRAME_LEN - 1);

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_SEND = 2'd1,
      CMD_DONE = 2'd2
   } cmd_type;

   // One unit of work handed from the front end to the framer.
   typedef struct packed {
      logic [RECORD_W-1:0] rec;
      logic                is_frame;
      logic                tx_ready;
      logic [COUNT_W-1:0]  count;
   } entry_type;

   function automatic idx_type next_slot(input idx_type i);
      idx_type r;
      if (i == idx_type'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] waiting(input idx_type tail, input idx_type head);
      logic [IDX_W:0] d;
      if (tail >= head) begin
         d = {1'b0, tail} - {1'b0, head};
      end else begin
         d = {1'b0, tail} + (IDX_W + 1)'(QUEUE_DEPTH) - {1'b0, head};
      end
      return COUNT_W'(d);
   endfunction

   // Frame byte order: timestamp, instant sample, average sample, all big-endian, then CR LF.
   function automatic logic [7:0] frame_byte(input logic [RECORD_W-1:0] rec,
                                             input logic [BYTE_IDX_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0: b = rec[63:56];
         4'd1: b = rec[55:48];
         4'd2: b = rec[47:40];
         4'd3: b = rec[39:32];
         4'd4: b = rec[31:24];
         4'd5: b = rec[23:16];
         4'd6: b = rec[15:8];
         4'd7: b = rec[7:0];
         4'd8: b = CHAR_CR;
         4'd9: b = CHAR_LF;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ src/overwrite_queue_record_framer_core.sv @@
// Channel   Direction  Payload
// req_*     in         tuser: cmd[1:0]; tdata: stamp, inst_sample, avg_sample
// rsp_*     out        tdata: out_byte, tx_ready, queue_count; tuser: byte_valid; tlast
//
// Push, transmit-complete and unused commands each give one status word. A send
// that frames a record holds the input while the record RAM read is registered,
// and gives ten words, one per cycle while the output is not stalled. A two-entry
// queue separates the front end from the framer; input stalls when it is full or
// while a send reads the record. Reset is synchronous; the record RAM is not cleared.
// Depends on oqrf_pkg, oqrf_front, oqrf_queue, oqrf_back.

module overwrite_queue_record_framer_core
   import oqrf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // stamp[31:0], inst_sample[47:32], avg_sample[63:48]
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_byte[7:0], tx_ready[8], queue_count[16:9], zero
   output logic        rsp_tuser,  // byte_valid[0]
   output logic        rsp_tlast
);

   logic                q_push, q_pop, q_full, q_not_empty;
   entry_type           push_entry, head_entry;
   logic [RECORD_W-1:0] rec;
   logic [7:0]          out_byte;
   logic                out_tx_ready;
   logic [COUNT_W-1:0]  out_count;

   // Stored layout: stamp high, instant sample, average sample low.
   assign rec = {req_tdata[31:0], req_tdata[47:32], req_tdata[63:48]};

   oqrf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_cmd   (req_tuser),
      .in_rec   (rec),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (push_entry)
   );

   oqrf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   oqrf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_entry        (head_entry),
      .q_not_empty    (q_not_empty),
      .q_pop          (q_pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_byte       (out_byte),
      .out_byte_valid (rsp_tuser),
      .out_last       (rsp_tlast),
      .out_tx_ready   (out_tx_ready),
      .out_count      (out_count)
   );

   assign rsp_tdata = {7'd0, out_count, out_tx_ready, out_byte};

   // A status word is always the only word of its command.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("status word without tlast");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'h00)
      else $error("status word carries a nonzero byte");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tlast |-> rsp_tdata[7:0] == CHAR_LF)
      else $error("frame does not end in LF");

   // During a frame the transmitter is always reported busy.
   a_frame_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[8])
      else $error("frame word reports transmitter ready");

endmodule

@@ src/oqrf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module oqrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/oqrf_front.sv @@
// Front end: accepts command words, keeps the ring indexes and busy flag,
// owns the record RAM and queues work entries. Depends on oqrf_pkg, oqrf_ram.

module oqrf_front
   import oqrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          in_cmd,
   input  logic [RECORD_W-1:0] in_rec,
   input  logic                q_full,
   output logic                q_push,
   output entry_type           q_entry
);

   idx_type            head_ff, head_in;
   idx_type            tail_ff, tail_in;
   logic               busy_ff, busy_in;
   logic               pend_ff, pend_in;
   logic [COUNT_W-1:0] pend_count_ff, pend_count_in;

   logic                accept;
   logic                ram_we;
   logic                ram_re;
   logic [RECORD_W-1:0] ram_rdata;
   idx_type             tail_next;

   oqrf_ram #(.WIDTH(RECORD_W), .DEPTH(QUEUE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (in_rec),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   // A send holds the input while the head record is read.
   assign in_ready  = !pend_ff && !q_full;
   assign accept    = in_valid && in_ready;
   assign tail_next = next_slot(tail_ff);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      busy_in       = busy_ff;
      pend_in       = 1'b0;
      pend_count_in = pend_count_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      q_push        = 1'b0;
      q_entry       = '{rec: ram_rdata, is_frame: 1'b0, tx_ready: !busy_ff,
                        count: waiting(tail_ff, head_ff)};
      if (pend_ff) begin
         q_push           = 1'b1;
         q_entry.is_frame = 1'b1;
         q_entry.tx_ready = 1'b0;
         q_entry.count    = pend_count_ff;
      end else if (accept) begin
         case (cmd_type'(in_cmd))
            CMD_PUSH: begin
               ram_we  = 1'b1;
               tail_in = tail_next;
               if (tail_next == head_ff) begin
                  head_in = next_slot(head_ff);
               end
               q_push        = 1'b1;
               q_entry.count = waiting(tail_in, head_in);
            end
            CMD_SEND: begin
               if (head_ff != tail_ff && !busy_ff) begin
                  ram_re        = 1'b1;
                  head_in       = next_slot(head_ff);
                  busy_in       = 1'b1;
                  pend_in       = 1'b1;
                  pend_count_in = waiting(tail_ff, head_in);
               end else begin
                  q_push = 1'b1;
               end
            end
            CMD_DONE: begin
               busy_in          = 1'b0;
               q_push           = 1'b1;
               q_entry.tx_ready = 1'b1;
            end
            default: begin
               q_push = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         busy_ff <= busy_in;
         pend_ff <= pend_in;
      end
      pend_count_ff <= pend_count_in;
   end

endmodule

@@ src/oqrf_queue.sv @@
// Two-entry queue of work entries between the front end and the framer.
// Depends on oqrf_pkg.

module oqrf_queue
   import oqrf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head_entry,
   output logic      not_empty,
   output logic      full
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_empty  = count_ff != 2'd0;
   assign full       = count_ff == 2'd2;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ src/oqrf_back.sv @@
// Framer: turns queued entries into result words, ten per frame or one status
// word, through a registered output stage. Depends on oqrf_pkg.

module oqrf_back
   import oqrf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  entry_type          q_entry,
   input  logic               q_not_empty,
   output logic               q_pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               out_byte_valid,
   output logic               out_last,
   output logic               out_tx_ready,
   output logic [COUNT_W-1:0] out_count
);

   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  bvalid_ff, bvalid_in;
   logic                  last_ff, last_in;
   logic                  txr_ff, txr_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  load;

   assign load = q_not_empty && (!valid_ff || out_ready);

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff && !out_ready;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;
      last_in   = last_ff;
      txr_in    = txr_ff;
      count_in  = count_ff;
      q_pop     = 1'b0;
      if (load) begin
         valid_in  = 1'b1;
         byte_in   = q_entry.is_frame ? frame_byte(q_entry.rec, idx_ff) : 8'h00;
         bvalid_in = q_entry.is_frame;
         last_in   = !q_entry.is_frame || idx_ff == LAST_BYTE_IDX;
         txr_in    = q_entry.tx_ready;
         count_in  = q_entry.count;
         if (last_in) begin
            q_pop  = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      last_ff   <= last_in;
      txr_ff    <= txr_in;
      count_ff  <= count_in;
   end

   assign out_valid      = valid_ff;
   assign out_byte       = byte_ff;
   assign out_byte_valid = bvalid_ff;
   assign out_last       = last_ff;
   assign out_tx_ready   = txr_ff;
   assign out_count      = count_ff;

endmodule

@@ tb/overwrite_queue_record_framer_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for overwrite_queue_record_framer_core: record pushes, frame sends,
// transmit-complete events and the unused command, checked word by word against a predictor.
// Depends on oqrf_pkg and the RTL under src.

module overwrite_queue_record_framer_core_tb;
   import oqrf_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS = 112;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] stamp;
      logic [15:0] inst_sample;
      logic [15:0] avg_sample;
   } command_word_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic       tx_ready;
      logic [7:0] queue_count;
   } frame_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // stamp[31:0], inst_sample[47:32], avg_sample[63:48]
   logic [1:0]  req_tuser = '0;  // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // out_byte[7:0], tx_ready[8], queue_count[16:9], zero
   logic        rsp_tuser;       // byte_valid[0]
   logic        rsp_tlast;

   command_word_type pending_cmds[$];
   frame_word_type   awaited_words[$];
   command_word_type next_cmd;
   command_word_type taken_cmd;
   frame_word_type   oldest;
   logic             req_taken = 1'b0;
   int unsigned      sender_idle_pct = 0;
   int unsigned      receiver_stall_pct = 0;
   int unsigned      mismatches = 0;
   int unsigned      cycle_count = 0;

   // Predictor state: the record ring, its indexes and the transmitter flag.
   logic [63:0] record_ring [QUEUE_DEPTH];
   int unsigned ring_head = 0;
   int unsigned ring_tail = 0;
   bit          tx_busy = 1'b0;

   overwrite_queue_record_framer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void add_command(logic [1:0] cmd, logic [31:0] stamp,
                                       logic [15:0] inst_sample, logic [15:0] avg_sample);
      command_word_type c;
      c.cmd = cmd;
      c.stamp = stamp;
      c.inst_sample = inst_sample;
      c.avg_sample = avg_sample;
      pending_cmds.push_back(c);
   endfunction

   // Payload is random for every command; only a push stores it.
   function automatic void add_random(logic [1:0] cmd);
      add_command(cmd, $urandom, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
   endfunction

   function automatic int unsigned records_held();
      return (ring_tail + QUEUE_DEPTH - ring_head) % QUEUE_DEPTH;
   endfunction

   function automatic void await_word(logic [7:0] b, logic valid, logic last);
      frame_word_type w;
      w.out_byte = b;
      w.byte_valid = valid;
      w.last = last;
      w.tx_ready = !tx_busy;
      w.queue_count = 8'(records_held());
      awaited_words.push_back(w);
   endfunction

   function automatic void apply_command(command_word_type c);
      logic [63:0] rec;
      if (c.cmd == CMD_PUSH) begin
         record_ring[ring_tail] = {c.stamp, c.inst_sample, c.avg_sample};
         ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
         // Catching the head drops the oldest record.
         if (ring_tail == ring_head) begin
            ring_head = (ring_head + 1) % QUEUE_DEPTH;
         end
         await_word(8'h00, 1'b0, 1'b1);
      end else if (c.cmd == CMD_SEND && ring_head != ring_tail && !tx_busy) begin
         rec = record_ring[ring_head];
         tx_busy = 1'b1;
         ring_head = (ring_head + 1) % QUEUE_DEPTH;
         for (int k = 0; k < 8; k++) begin
            await_word(rec[63 - 8 * k -: 8], 1'b1, 1'b0);
         end
         await_word(CHAR_CR, 1'b1, 1'b0);
         await_word(CHAR_LF, 1'b1, 1'b1);
      end else begin
         if (c.cmd == CMD_DONE) begin
            tx_busy = 1'b0;
         end
         await_word(8'h00, 1'b0, 1'b1);
      end
   endfunction

   task automatic check_field(string name, int unsigned expected, int unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0h, got %0h", name, expected, actual);
         mismatches++;
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_tvalid || awaited_words.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Driver: a word is held until taken, then the next one is offered or the line idles.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_cmd = pending_cmds.pop_front();
            req_tuser <= next_cmd.cmd;
            req_tdata <= {next_cmd.avg_sample, next_cmd.inst_sample, next_cmd.stamp};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Monitor: the result is checked before the input taken at the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         ring_head = 0;
         ring_tail = 0;
         tx_busy = 1'b0;
         awaited_words.delete();
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_words.size() == 0) begin
               $error("result word arrived with none awaited");
               mismatches++;
            end else begin
               oldest = awaited_words.pop_front();
               check_field("out_byte", oldest.out_byte, rsp_tdata[7:0]);
               check_field("byte_valid", oldest.byte_valid, rsp_tuser);
               check_field("last", oldest.last, rsp_tlast);
               check_field("tx_ready", oldest.tx_ready, rsp_tdata[8]);
               check_field("queue_count", oldest.queue_count, rsp_tdata[16:9]);
            end
         end
         if (req_tvalid && req_tready) begin
            taken_cmd.cmd = req_tuser;
            taken_cmd.stamp = req_tdata[31:0];
            taken_cmd.inst_sample = req_tdata[47:32];
            taken_cmd.avg_sample = req_tdata[63:48];
            apply_command(taken_cmd);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int unsigned phase_count;
      int unsigned burst;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty and idle corner cases, field extremes, a busy send, overflow.
      add_random(CMD_SEND);
      add_random(CMD_DONE);
      add_random(CMD_UNUSED);
      add_command(CMD_PUSH, 32'h0000_0000, 16'h0000, 16'h0000);
      add_command(CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      add_command(CMD_PUSH, 32'h1234_5678, 16'hABCD, 16'h5A5A);
      add_random(CMD_SEND);
      add_random(CMD_SEND);
      add_random(CMD_DONE);
      add_random(CMD_SEND);
      add_random(CMD_DONE);
      for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
         add_random(CMD_PUSH);
      end
      add_random(CMD_SEND);
      add_random(CMD_DONE);
      add_command(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      // The sender holds off here until every awaited word has come back.
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 65;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 65;
            end
            default: begin
               sender_idle_pct = 27;
               receiver_stall_pct = 27;
            end
         endcase
         phase_count = 0;
         // Episodes: a burst of pushes, sometimes past full, then send and
         // complete pairs, with the odd repeated send and stray command.
         while (phase_count < PHASE_ITEMS) begin
            burst = $urandom_range(1, QUEUE_DEPTH + 2);
            for (int i = 0; i < burst; i++) begin
               add_random(CMD_PUSH);
            end
            phase_count += burst;
            burst = $urandom_range(1, 4);
            for (int i = 0; i < burst; i++) begin
               add_random(CMD_SEND);
               phase_count++;
               if ($urandom_range(0, 99) < 20) begin
                  add_random(CMD_SEND);
                  phase_count++;
               end
               add_random(CMD_DONE);
               phase_count++;
            end
            if ($urandom_range(0, 99) < 30) begin
               add_random(2'($urandom_range(0, 3)));
               phase_count++;
            end
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
